/* rtl/assert_macros.svh */
// Assertion macros used by the port checker.
// Depends on nothing; expects clk and rst in the scope of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every clock edge outside reset.
`define PPS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check on every clock edge, reset included.
`define PPS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/pps_pkg.sv */
// Shared types and constants of the preemptive priority scheduler.
// Used by the top level, the port checker and the testbench.
package pps_pkg;

  localparam int SLOTS_DEF = 8;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef struct packed {
    logic        operation;
    logic [2:0]  slot;
    logic [7:0]  proc_id;
    logic [7:0]  priority_req;
    logic [15:0] arrival;
    logic [15:0] burst;
  } req_t;

  typedef struct packed {
    logic        idle;
    logic [7:0]  chosen_id;
    logic [15:0] start_time;
    logic [15:0] finish_time;
    logic        completed;
    logic        all_done;
  } rsp_t;

  typedef struct packed {
    logic [7:0]  id;
    logic [7:0]  prio;
    logic [15:0] arrival;
    logic [15:0] remaining;
  } entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE,
    ST_EMIT
  } state_t;

endpackage

/* rtl/pps_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read.
// Depends on nothing.
module pps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH)-1:0]         waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic [$clog2(DEPTH)-1:0]         raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/preemptive_priority_scheduler.sv */
// Preemptive priority scheduler: a load request is written in the cycle it is
// accepted; a tick request scans one slot per cycle through the slot RAM read
// port, and the scheduler becomes ready again when the tick's result turns valid.
// Reset clears slot valid bits, the time counter and the response valid flag;
// no clearing pass is needed. Depends on pps_pkg and pps_ram.
module preemptive_priority_scheduler #(
  parameter int SLOTS = pps_pkg::SLOTS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  pps_pkg::req_t req_data,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output pps_pkg::rsp_t rsp_data
);

  localparam int IDX_W = $clog2(SLOTS);
  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(SLOTS);

  pps_pkg::state_t state, state_next;
  logic [CNT_W-1:0] cnt;
  logic [SLOTS-1:0] valid;
  logic [15:0]      cur_time;
  logic             have_pick;
  logic [1:0]       work_cnt;
  logic [IDX_W-1:0] best_idx;
  pps_pkg::entry_t  best;
  logic [IDX_W-1:0] rd_idx;
  logic             rd_vld;
  pps_pkg::entry_t  rd_entry;
  pps_pkg::rsp_t    res;

  logic             we;
  logic [IDX_W-1:0] waddr;
  pps_pkg::entry_t  wdata;
  logic [IDX_W-1:0] raddr;

  logic             load_fire;
  logic             tick_fire;
  logic             eval_on;
  logic             has_work;
  logic             take;
  logic             out_free;
  logic [15:0]      new_rem;

  pps_ram #(
    .WIDTH($bits(pps_pkg::entry_t)),
    .DEPTH(SLOTS)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rd_entry)
  );

  assign load_fire = req_valid && req_ready && (req_data.operation == pps_pkg::OP_LOAD)
                     && (int'(req_data.slot) < SLOTS);
  assign tick_fire = req_valid && req_ready && (req_data.operation == pps_pkg::OP_TICK);
  assign eval_on   = (state == pps_pkg::ST_SCAN) && (cnt != '0);
  assign has_work  = eval_on && rd_vld && (rd_entry.remaining != 16'd0);
  assign take      = has_work && (rd_entry.arrival <= cur_time)
                     && (!have_pick || (rd_entry.prio > best.prio));
  assign out_free  = !rsp_valid || rsp_ready;
  assign new_rem   = best.remaining - 16'd1;

  always_comb begin
    state_next = state;
    unique case (state)
      pps_pkg::ST_IDLE:   if (tick_fire) state_next = pps_pkg::ST_SCAN;
      pps_pkg::ST_SCAN:   if (cnt == LAST) state_next = pps_pkg::ST_UPDATE;
      pps_pkg::ST_UPDATE: state_next = pps_pkg::ST_EMIT;
      pps_pkg::ST_EMIT:   if (out_free) state_next = pps_pkg::ST_IDLE;
      default:            state_next = pps_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    req_ready = (state == pps_pkg::ST_IDLE);
    raddr     = (cnt < LAST) ? cnt[IDX_W-1:0] : '0;
    if (state == pps_pkg::ST_UPDATE) begin
      we              = have_pick;
      waddr           = best_idx;
      wdata           = best;
      wdata.remaining = new_rem;
    end else begin
      we              = load_fire;
      waddr           = IDX_W'(req_data.slot);
      wdata.id        = req_data.proc_id;
      wdata.prio      = req_data.priority_req;
      wdata.arrival   = req_data.arrival;
      wdata.remaining = req_data.burst;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= pps_pkg::ST_IDLE;
      cnt       <= '0;
      valid     <= '0;
      cur_time  <= 16'd0;
      have_pick <= 1'b0;
      work_cnt  <= 2'd0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_fire) begin
        valid[IDX_W'(req_data.slot)] <= 1'b1;
      end
      if (tick_fire) begin
        cnt       <= '0;
        have_pick <= 1'b0;
        work_cnt  <= 2'd0;
      end
      if ((state == pps_pkg::ST_SCAN) && (cnt != LAST)) begin
        cnt <= cnt + CNT_W'(1);
      end
      if (take) begin
        have_pick <= 1'b1;
      end
      if (has_work && (work_cnt != 2'd2)) begin
        work_cnt <= work_cnt + 2'd1;
      end
      if (state == pps_pkg::ST_UPDATE) begin
        cur_time <= cur_time + 16'd1;
      end
      if ((state == pps_pkg::ST_EMIT) && out_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_vld <= valid[raddr];
    rd_idx <= raddr;
    if (take) begin
      best     <= rd_entry;
      best_idx <= rd_idx;
    end
    if (state == pps_pkg::ST_UPDATE) begin
      res.idle        <= !have_pick;
      res.chosen_id   <= have_pick ? best.id : 8'd0;
      res.start_time  <= cur_time;
      res.finish_time <= cur_time + 16'd1;
      res.completed   <= have_pick && (new_rem == 16'd0);
      res.all_done    <= have_pick ? ((new_rem == 16'd0) && (work_cnt == 2'd1))
                                   : (work_cnt == 2'd0);
    end
    if ((state == pps_pkg::ST_EMIT) && out_free) begin
      rsp_data <= res;
    end
  end

endmodule

/* rtl/pps_checker.sv */
// Port-level checker for the preemptive priority scheduler, bound to the top.
// Depends on pps_pkg and assert_macros.svh.
`include "assert_macros.svh"

module pps_checker (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_ready,
  input pps_pkg::req_t req_data,
  input logic          rsp_valid,
  input logic          rsp_ready,
  input pps_pkg::rsp_t rsp_data
);

  `PPS_ASSERT_ALWAYS(a_rst_clears, rst |=> !rsp_valid, "response valid after reset")
  `PPS_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data), "stalled response changed")
  `PPS_ASSERT(a_finish, rsp_valid |-> rsp_data.finish_time == 16'(rsp_data.start_time + 16'd1), "finish time is not start plus one")
  `PPS_ASSERT(a_idle_tick, rsp_valid && rsp_data.idle |-> rsp_data.chosen_id == 8'd0 && !rsp_data.completed, "idle tick reports a process")
  `PPS_ASSERT(a_tick_busy, req_valid && req_ready && req_data.operation == pps_pkg::OP_TICK |=> !req_ready, "ready during a tick scan")

endmodule

bind preemptive_priority_scheduler pps_checker u_pps_checker (
  .clk      (clk),
  .rst      (rst),
  .req_valid(req_valid),
  .req_ready(req_ready),
  .req_data (req_data),
  .rsp_valid(rsp_valid),
  .rsp_ready(rsp_ready),
  .rsp_data (rsp_data)
);

/* test/tb_preemptive_priority_scheduler.sv */
// Testbench for preemptive_priority_scheduler: directed table and random load/tick
// traffic under varied idling, checked against a local scheduler.
// Depends on pps_pkg and the scheduler RTL.
module tb_preemptive_priority_scheduler;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS       = pps_pkg::SLOTS_DEF;
  localparam int STALL_LIMIT = 2000;
  localparam int PHASE_ITEMS = 440;
  localparam int MAX_PRINTS  = 100;

  typedef struct packed {
    pps_pkg::req_t req;
    logic          typed;
    pps_pkg::rsp_t rsp;
  } step_t;

  localparam pps_pkg::req_t TICK_REQ =
    '{pps_pkg::OP_TICK, 3'd0, 8'h00, 8'h00, 16'h0000, 16'h0000};
  localparam pps_pkg::rsp_t NO_RSP   = '0;

  localparam step_t DIRECTED [23] = '{
    '{TICK_REQ, 1'b1, '{1'b1, 8'h00, 16'd0, 16'd1, 1'b0, 1'b1}},
    '{'{pps_pkg::OP_LOAD, 3'd0, 8'hFF, 8'hFF, 16'h0000, 16'h0001}, 1'b0, NO_RSP},
    '{TICK_REQ, 1'b1, '{1'b0, 8'hFF, 16'd1, 16'd2, 1'b1, 1'b1}},
    '{'{pps_pkg::OP_LOAD, 3'd7, 8'h00, 8'h00, 16'hFFFF, 16'hFFFF}, 1'b0, NO_RSP},
    '{TICK_REQ, 1'b1, '{1'b1, 8'h00, 16'd2, 16'd3, 1'b0, 1'b0}},
    '{'{pps_pkg::OP_LOAD, 3'd3, 8'h33, 8'h05, 16'h0000, 16'h0002}, 1'b0, NO_RSP},
    '{'{pps_pkg::OP_LOAD, 3'd5, 8'h55, 8'h05, 16'h0000, 16'h0002}, 1'b0, NO_RSP},
    '{TICK_REQ, 1'b0, NO_RSP},
    '{'{pps_pkg::OP_LOAD, 3'd2, 8'h22, 8'hFF, 16'h0000, 16'h0000}, 1'b0, NO_RSP},
    '{'{pps_pkg::OP_LOAD, 3'd1, 8'h11, 8'h09, 16'h0008, 16'h0003}, 1'b0, NO_RSP},
    '{TICK_REQ, 1'b0, NO_RSP},
    '{TICK_REQ, 1'b0, NO_RSP},
    '{'{pps_pkg::OP_LOAD, 3'd5, 8'h5A, 8'h80, 16'h0000, 16'h0001}, 1'b0, NO_RSP},
    '{TICK_REQ, 1'b0, NO_RSP},
    '{TICK_REQ, 1'b0, NO_RSP},
    '{TICK_REQ, 1'b0, NO_RSP},
    '{TICK_REQ, 1'b0, NO_RSP},
    '{TICK_REQ, 1'b0, NO_RSP},
    '{TICK_REQ, 1'b0, NO_RSP},
    '{'{pps_pkg::OP_LOAD, 3'd6, 8'hAA, 8'h55, 16'h00FF, 16'h0002}, 1'b0, NO_RSP},
    '{'{pps_pkg::OP_LOAD, 3'd4, 8'h44, 8'h01, 16'h0000, 16'h0100}, 1'b0, NO_RSP},
    '{TICK_REQ, 1'b0, NO_RSP},
    '{TICK_REQ, 1'b0, NO_RSP}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  pps_pkg::req_t req_data = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  pps_pkg::rsp_t rsp_data;

  logic [7:0]  slot_id      [SLOTS];
  logic [7:0]  slot_prio    [SLOTS];
  logic [15:0] slot_arrival [SLOTS];
  logic [15:0] slot_work    [SLOTS] = '{default: 16'd0};
  logic [15:0] sched_time = 16'd0;

  pps_pkg::rsp_t expected_ticks [$];
  logic          use_typed = 1'b0;
  pps_pkg::rsp_t typed_rsp = '0;
  int   mismatches = 0;
  int   quiet_cycles = 0;
  int   send_idle_pct = 0;
  int   rsp_stall_pct = 0;

  preemptive_priority_scheduler dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req_data(req_data),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp_data(rsp_data)
  );

  always #4 clk = ~clk;

  function automatic void load_slot(input pps_pkg::req_t r);
    if (int'(r.slot) < SLOTS) begin
      slot_id[r.slot]      = r.proc_id;
      slot_prio[r.slot]    = r.priority_req;
      slot_arrival[r.slot] = r.arrival;
      slot_work[r.slot]    = r.burst;
    end
  endfunction

  function automatic pps_pkg::rsp_t schedule_tick();
    int            pick;
    pps_pkg::rsp_t r;
    pick = -1;
    for (int k = 0; k < SLOTS; k++) begin
      if (slot_work[k] != 16'd0 && slot_arrival[k] <= sched_time) begin
        if (pick < 0 || slot_prio[k] > slot_prio[pick]) pick = k;
      end
    end
    r = '0;
    r.idle = (pick < 0);
    r.start_time = sched_time;
    if (pick >= 0) begin
      slot_work[pick] = slot_work[pick] - 16'd1;
      r.chosen_id = slot_id[pick];
      r.completed = (slot_work[pick] == 16'd0);
    end
    r.all_done = 1'b1;
    for (int k = 0; k < SLOTS; k++) begin
      if (slot_work[k] != 16'd0) r.all_done = 1'b0;
    end
    sched_time = sched_time + 16'd1;
    r.finish_time = sched_time;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    mismatches++;
    if (mismatches <= MAX_PRINTS)
      $display("%0t: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
  endtask

  always @(negedge clk) begin
    rsp_ready <= (rsp_stall_pct == 0) || ($urandom_range(99) >= rsp_stall_pct);
  end

  always @(posedge clk) begin : monitor
    pps_pkg::rsp_t got;
    pps_pkg::rsp_t want;
    if (!rst) begin
      if (rsp_valid === 1'b1 && rsp_ready) begin
        got = rsp_data;
        if (expected_ticks.size() == 0) begin
          report_mismatch("result with none pending", got.start_time, 16'd0);
        end else begin
          want = expected_ticks.pop_front();
          if (got.idle !== want.idle) report_mismatch("idle", got.idle, want.idle);
          if (got.chosen_id !== want.chosen_id)
            report_mismatch("chosen_id", got.chosen_id, want.chosen_id);
          if (got.start_time !== want.start_time)
            report_mismatch("start_time", got.start_time, want.start_time);
          if (got.finish_time !== want.finish_time)
            report_mismatch("finish_time", got.finish_time, want.finish_time);
          if (got.completed !== want.completed)
            report_mismatch("completed", got.completed, want.completed);
          if (got.all_done !== want.all_done)
            report_mismatch("all_done", got.all_done, want.all_done);
        end
      end
      if (req_valid && req_ready === 1'b1) begin
        if (req_data.operation == pps_pkg::OP_LOAD) begin
          load_slot(req_data);
        end else begin
          want = schedule_tick();
          if (use_typed) want = typed_rsp;
          expected_ticks.push_back(want);
        end
      end
      if ((req_valid && req_ready === 1'b1) || (rsp_valid === 1'b1 && rsp_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no request or result moved for %0d cycles", $time, STALL_LIMIT);
        $display("** preemptive_priority_scheduler: FAILED **");
        $finish;
      end
    end
  end

  task automatic send_request(input pps_pkg::req_t r);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid <= 1'b1;
    req_data  <= r;
    do @(posedge clk); while (req_ready !== 1'b1);
    @(negedge clk);
  endtask

  task automatic wait_drain();
    do @(negedge clk); while (expected_ticks.size() != 0);
  endtask

  initial begin : stimulus
    pps_pkg::req_t item;
    logic [15:0]   now;
    int            pick;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (DIRECTED[i]) begin
      use_typed = DIRECTED[i].typed;
      typed_rsp = DIRECTED[i].rsp;
      send_request(DIRECTED[i].req);
    end
    use_typed = 1'b0;
    req_valid <= 1'b0;
    wait_drain();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
        1: begin send_idle_pct = 71; rsp_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  rsp_stall_pct = 71; end
        default: begin send_idle_pct = 27; rsp_stall_pct = 27; end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(99) == 0) begin
          req_valid <= 1'b0;
          wait_drain();
        end
        now  = sched_time;
        pick = $urandom_range(99);
        item.operation    = (pick < 45) ? pps_pkg::OP_LOAD : pps_pkg::OP_TICK;
        item.slot         = 3'($urandom);
        item.proc_id      = 8'($urandom);
        item.priority_req = ($urandom_range(1) == 0) ? 8'($urandom)
                          : {$urandom_range(1) == 0 ? 1'b0 : 1'b1, 6'd0,
                             $urandom_range(1) == 0 ? 1'b0 : 1'b1};
        pick = $urandom_range(99);
        if (pick < 60)      item.arrival = now + 16'($urandom_range(6)) - 16'd3;
        else if (pick < 85) item.arrival = now - 16'($urandom_range(255));
        else                item.arrival = 16'($urandom);
        pick = $urandom_range(99);
        if (pick < 10)      item.burst = 16'd0;
        else if (pick < 80) item.burst = 16'($urandom_range(6, 1));
        else if (pick < 95) item.burst = 16'($urandom_range(40, 7));
        else                item.burst = 16'($urandom);
        send_request(item);
      end
      req_valid <= 1'b0;
      wait_drain();
    end

    send_idle_pct = 0;
    rsp_stall_pct = 0;
    repeat (SLOTS + 8) @(posedge clk);
    if (expected_ticks.size() != 0)
      report_mismatch("results never returned", 16'(expected_ticks.size()), 16'd0);
    if (mismatches == 0)
      $display("** preemptive_priority_scheduler: PASSED **");
    else
      $display("** preemptive_priority_scheduler: FAILED **");
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl
rtl/pps_pkg.sv
rtl/pps_ram.sv
rtl/preemptive_priority_scheduler.sv
rtl/pps_checker.sv
test/tb_preemptive_priority_scheduler.sv
